@@ hw/rtl/chunked_file_receive_tracker_unit_assert.svh @@
// Assertion macros for the chunked file receive tracker
`ifndef CHUNKED_FILE_RECEIVE_TRACKER_UNIT_ASSERT_SVH
`define CHUNKED_FILE_RECEIVE_TRACKER_UNIT_ASSERT_SVH
// Check that an implication holds on every clock edge outside reset
`define CFRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that an expression holds in the cycle after a condition
`define CFRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/cfrt_pkg.sv @@
// Package: constants, event codes and types of the chunked file receive tracker
package cfrt_pkg;
  localparam int MaxSlots = 8;
  localparam int MaxChunks = 32;
  localparam int SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int ChunkW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int CountW = $clog2(MaxChunks + 1);

  typedef enum logic [1:0] {
    REQ_DEF  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_END  = 2'd2,
    REQ_OTHER = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    EV_BAD_FILE   = 4'd0,
    EV_DONE       = 4'd1,
    EV_DUP_DEF    = 4'd2,
    EV_BAD_DEF    = 4'd3,
    EV_DEF_OK     = 4'd4,
    EV_NO_DEF     = 4'd5,
    EV_BAD_SEQ    = 4'd6,
    EV_CORRUPT    = 4'd7,
    EV_STORED     = 4'd8,
    EV_DUP_CHUNK  = 4'd9,
    EV_COMPLETE   = 4'd10,
    EV_INTEG_FAIL = 4'd11,
    EV_RESEND     = 4'd12,
    EV_IGNORED    = 4'd13
  } event_t;

  // Control from the sequencer to the shared compare unit
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;
endpackage

@@ hw/rtl/cfrt_cmp.sv @@
// Shared 32-bit adder and equality compare used by the sequencer
module cfrt_cmp
  import cfrt_pkg::*;
(
  input  cmp_req_t    req,
  output logic [31:0] sum,
  output logic        equal
);
  assign sum   = req.a + req.b;
  assign equal = (req.a == req.b);
endmodule

@@ hw/rtl/chunked_file_receive_tracker_unit.sv @@
// Top level: chunked file receive tracker with a small sequencer and one shared add/compare unit
// Usage:
//   Input channel: in_valid/in_stall with one port per request field. A request
//   is taken when in_valid is high and in_stall is low.
//   Output channel: out_valid/out_stall carrying event_code, out_file, out_seq
//   and out_last; out_last marks the last event of one request.
//   A data byte that is not last gives no event. A stored chunk gives a second
//   event when it is the last chunk of its file. An end request for a file
//   with missing chunks walks the chunk map, chunk by chunk, and asks for
//   each missing chunk again. Events leave through a registered output stage,
//   and in_stall stays high while a request is at work or an event waits.
//   The walk over the chunk map sets the worst-case latency.
//   A stalled output holds its event until taken; the walk pauses meanwhile.
//   Reset clears every slot (active, done, counts, maps, sums) and the
//   partial chunk sum at once, all slot state being in flip-flops.
`include "chunked_file_receive_tracker_unit_assert.svh"
module chunked_file_receive_tracker_unit
  import cfrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  file_id,
  input  logic [15:0] seq_num,
  input  logic [15:0] chunk_total,
  input  logic [31:0] check_value,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        byte_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_code,
  output logic [7:0]  out_file,
  output logic [15:0] out_seq,
  output logic        out_last
);
  typedef enum logic [2:0] {
    S_IDLE, S_DATA_CHK, S_DATA_ADD, S_END_CHK, S_WALK, S_EMIT
  } state_t;

  state_t state;
  logic [MaxSlots-1:0]  slot_active, slot_done;
  logic [CountW-1:0]    slot_total [MaxSlots];
  logic [CountW-1:0]    slot_count [MaxSlots];
  logic [MaxChunks-1:0] slot_have_map [MaxSlots];
  logic [31:0]          slot_expect_sum [MaxSlots];
  logic [31:0]          slot_running_sum [MaxSlots];
  logic [31:0]          chunk_sum;

  // latched request
  logic [1:0]  r_type;
  logic [7:0]  r_file;
  logic [15:0] r_seq;
  logic [31:0] r_check;
  logic [31:0] r_sum;
  logic [CountW-1:0] walk;
  logic        pend_fin;
  logic        pend_ok;

  cmp_req_t    cmp;
  logic [31:0] cmp_sum;
  logic        cmp_eq;

  cfrt_cmp u_cmp (.req(cmp), .sum(cmp_sum), .equal(cmp_eq));

  logic [SlotW-1:0] fs;
  logic [ChunkW-1:0] cs;
  logic              file_ok;
  logic [15:0]       in_total_q;
  assign fs      = r_file[SlotW-1:0];
  assign cs      = r_seq[ChunkW-1:0];
  assign file_ok = ({24'd0, r_file} < 32'(MaxSlots));

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmp.a = 32'd0;
    cmp.b = 32'd0;
    case (state)
      S_IDLE:     begin cmp.a = chunk_sum; cmp.b = {24'd0, data_byte}; end
      S_DATA_CHK: begin cmp.a = r_sum; cmp.b = r_check; end
      S_DATA_ADD: begin cmp.a = slot_running_sum[fs]; cmp.b = r_sum; end
      S_END_CHK:  begin cmp.a = slot_running_sum[fs]; cmp.b = slot_expect_sum[fs]; end
      default:    begin cmp.a = 32'd0; cmp.b = 32'd0; end
    endcase
  end

  task automatic put(input event_t c, input logic [15:0] s, input logic l);
    out_valid  <= 1'b1;
    event_code <= c;
    out_file   <= r_file;
    out_seq    <= s;
    out_last   <= l;
  endtask

  function automatic logic rest_missing(input logic [MaxChunks-1:0] m,
                                        input logic [CountW-1:0] tot,
                                        input logic [CountW-1:0] w);
    logic r;
    r = 1'b0;
    for (int j = 0; j < MaxChunks; j++)
      if (32'(j) > 32'(w) && 32'(j) < 32'(tot) && !m[j]) r = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      slot_active <= '0;
      slot_done   <= '0;
      chunk_sum   <= 32'd0;
      pend_fin    <= 1'b0;
      pend_ok     <= 1'b0;
      for (int i = 0; i < MaxSlots; i++) begin
        slot_total[i]       <= '0;
        slot_count[i]       <= '0;
        slot_have_map[i]    <= '0;
        slot_expect_sum[i]  <= '0;
        slot_running_sum[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            r_type     <= req_type;
            r_file     <= file_id;
            r_seq      <= seq_num;
            r_check    <= check_value;
            in_total_q <= chunk_total;
            if (req_type == REQ_DATA) begin
              if (byte_last) begin
                r_sum     <= byte_valid ? cmp_sum : chunk_sum;
                chunk_sum <= 32'd0;
                state     <= S_DATA_CHK;
              end else if (byte_valid) begin
                chunk_sum <= cmp_sum;
              end
            end else begin
              chunk_sum <= 32'd0;
              state     <= S_END_CHK;
            end
          end
        end
        S_DATA_CHK: begin
          state <= S_EMIT;
          if (!file_ok) put(EV_BAD_FILE, 16'd0, 1'b1);
          else if (slot_done[fs]) put(EV_DONE, 16'd0, 1'b1);
          else if (!slot_active[fs]) put(EV_NO_DEF, 16'd0, 1'b1);
          else if ({16'd0, r_seq} >= 32'(slot_total[fs])) put(EV_BAD_SEQ, r_seq, 1'b1);
          else if (!cmp_eq) put(EV_CORRUPT, r_seq, 1'b1);
          else if (slot_have_map[fs][cs]) put(EV_DUP_CHUNK, r_seq, 1'b1);
          else state <= S_DATA_ADD;
        end
        S_DATA_ADD: begin
          slot_have_map[fs][cs] <= 1'b1;
          slot_count[fs]        <= slot_count[fs] + 1'b1;
          slot_running_sum[fs]  <= cmp_sum;
          pend_fin <= (slot_count[fs] + 1'b1) == slot_total[fs];
          pend_ok  <= (cmp_sum == slot_expect_sum[fs]);
          put(EV_STORED, r_seq, !((slot_count[fs] + 1'b1) == slot_total[fs]));
          state <= S_EMIT;
        end
        S_END_CHK: begin
          state <= S_EMIT;
          if (r_type == REQ_OTHER) put(EV_IGNORED, 16'd0, 1'b1);
          else if (!file_ok) put(EV_BAD_FILE, 16'd0, 1'b1);
          else if (slot_done[fs]) put(EV_DONE, 16'd0, 1'b1);
          else if (r_type == REQ_DEF) begin
            if (slot_active[fs]) put(EV_DUP_DEF, 16'd0, 1'b1);
            else if (in_total_q == 16'd0 || {16'd0, in_total_q} > 32'(MaxChunks))
              put(EV_BAD_DEF, 16'd0, 1'b1);
            else begin
              slot_active[fs]      <= 1'b1;
              slot_total[fs]       <= in_total_q[CountW-1:0];
              slot_count[fs]       <= '0;
              slot_have_map[fs]    <= '0;
              slot_expect_sum[fs]  <= r_check;
              slot_running_sum[fs] <= '0;
              put(EV_DEF_OK, 16'd0, 1'b1);
            end
          end else if (!slot_active[fs]) put(EV_NO_DEF, 16'd0, 1'b1);
          else if (slot_count[fs] == slot_total[fs] && cmp_eq) begin
            slot_done[fs]   <= 1'b1;
            slot_active[fs] <= 1'b0;
            put(EV_COMPLETE, 16'd0, 1'b1);
          end else begin
            put(EV_INTEG_FAIL, 16'd0, slot_count[fs] == slot_total[fs]);
            walk  <= '0;
            state <= (slot_count[fs] == slot_total[fs]) ? S_EMIT : S_WALK;
          end
        end
        S_WALK: begin
          // advance one chunk per cycle; hold while the output is busy
          if (out_free) begin
            if (walk >= slot_total[fs]) state <= S_EMIT;
            else begin
              walk <= walk + 1'b1;
              // last resend when no missing chunk remains past walk
              if (!slot_have_map[fs][walk[ChunkW-1:0]])
                put(EV_RESEND, 16'(walk),
                    !rest_missing(slot_have_map[fs], slot_total[fs], walk));
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (pend_fin) begin
              pend_fin <= 1'b0;
              if (pend_ok) begin
                slot_done[fs]   <= 1'b1;
                slot_active[fs] <= 1'b0;
                put(EV_COMPLETE, 16'd0, 1'b1);
              end else put(EV_INTEG_FAIL, 16'd0, 1'b1);
            end else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CFRT_ASSERT_IMPL(a_busy_stall, state != S_IDLE, in_stall, "busy but not stalling")
  `CFRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled event dropped")
  `CFRT_ASSERT_IMPL(a_slot_excl, 1'b1, (slot_active & slot_done) == '0,
    "slot both active and done")
endmodule

@@ tb/sv/cfrt_checker.sv @@
// Checker: watches both channels of the file receive tracker, predicts events and compares
module cfrt_checker
  import cfrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  file_id,
  input  logic [15:0] seq_num,
  input  logic [15:0] chunk_total,
  input  logic [31:0] check_value,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        byte_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  event_code,
  input  logic [7:0]  out_file,
  input  logic [15:0] out_seq,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          event_total
);

  typedef struct packed {
    event_t      code;
    logic [7:0]  file;
    logic [15:0] seq;
    logic        last;
  } tracker_event_t;

  tracker_event_t due_events[$];

  logic                 active_q  [MaxSlots];
  logic                 done_q    [MaxSlots];
  logic [6:0]           total_q   [MaxSlots];
  logic [6:0]           count_q   [MaxSlots];
  logic [MaxChunks-1:0] have_q    [MaxSlots];
  logic [31:0]          goal_sum_q[MaxSlots];
  logic [31:0]          run_sum_q [MaxSlots];
  logic [31:0]          partial_sum;

  assign pending = due_events.size();

  function automatic void push_event(event_t c, logic [7:0] f, logic [15:0] s);
    tracker_event_t e;
    e.code = c;
    e.file = f;
    e.seq  = s;
    e.last = 1'b0;
    due_events.push_back(e);
  endfunction

  task automatic track_request(logic [1:0] rt, logic [7:0] f, logic [15:0] sq,
                               logic [15:0] tot, logic [31:0] chk, logic [7:0] b,
                               logic bv, logic bl);
    int before_n;
    logic [31:0] sum;
    int s;
    before_n = due_events.size();
    s = f;
    if (rt == REQ_DATA) begin
      if (bv) partial_sum += b;
      if (!bl) return;
      sum = partial_sum;
      partial_sum = '0;
      if (f >= MaxSlots) push_event(EV_BAD_FILE, f, 0);
      else if (done_q[s]) push_event(EV_DONE, f, 0);
      else if (!active_q[s]) push_event(EV_NO_DEF, f, 0);
      else if (sq >= total_q[s]) push_event(EV_BAD_SEQ, f, sq);
      else if (sum != chk) push_event(EV_CORRUPT, f, sq);
      else if (have_q[s][sq]) push_event(EV_DUP_CHUNK, f, sq);
      else begin
        have_q[s][sq] = 1'b1;
        count_q[s] += 1;
        run_sum_q[s] += sum;
        push_event(EV_STORED, f, sq);
        if (count_q[s] == total_q[s]) begin
          if (run_sum_q[s] == goal_sum_q[s]) begin
            done_q[s] = 1'b1;
            active_q[s] = 1'b0;
            push_event(EV_COMPLETE, f, 0);
          end else begin
            push_event(EV_INTEG_FAIL, f, 0);
          end
        end
      end
    end else begin
      partial_sum = '0;
      if (rt == REQ_OTHER) push_event(EV_IGNORED, f, 0);
      else if (f >= MaxSlots) push_event(EV_BAD_FILE, f, 0);
      else if (done_q[s]) push_event(EV_DONE, f, 0);
      else if (rt == REQ_DEF) begin
        if (active_q[s]) push_event(EV_DUP_DEF, f, 0);
        else if (tot == 0 || tot > MaxChunks) push_event(EV_BAD_DEF, f, 0);
        else begin
          active_q[s] = 1'b1;
          total_q[s] = tot[6:0];
          count_q[s] = '0;
          have_q[s] = '0;
          goal_sum_q[s] = chk;
          run_sum_q[s] = '0;
          push_event(EV_DEF_OK, f, 0);
        end
      end else if (!active_q[s]) push_event(EV_NO_DEF, f, 0);
      else if (count_q[s] == total_q[s] && run_sum_q[s] == goal_sum_q[s]) begin
        done_q[s] = 1'b1;
        active_q[s] = 1'b0;
        push_event(EV_COMPLETE, f, 0);
      end else begin
        push_event(EV_INTEG_FAIL, f, 0);
        for (int j = 0; j < total_q[s]; j++)
          if (!have_q[s][j]) push_event(EV_RESEND, f, 16'(j));
      end
    end
    if (due_events.size() > before_n) due_events[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    tracker_event_t want;
    if (rst) begin
      fail_count <= 0;
      event_total <= 0;
      due_events.delete();
      partial_sum = '0;
      for (int i = 0; i < MaxSlots; i++) begin
        active_q[i] = 0; done_q[i] = 0; total_q[i] = 0; count_q[i] = 0;
        have_q[i] = '0; goal_sum_q[i] = '0; run_sum_q[i] = '0;
      end
    end else begin
      if (in_valid && !in_stall)
        track_request(req_type, file_id, seq_num, chunk_total, check_value,
                      data_byte, byte_valid, byte_last);
      if (out_valid && !out_stall) begin
        event_total <= event_total + 1;
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event code=%0d file=%0d seq=%0d last=%0b",
                   $time, event_code, out_file, out_seq, out_last);
          fail_count <= fail_count + 1;
        end else begin
          want = due_events.pop_front();
          if (want.code !== event_code || want.file !== out_file ||
              want.seq !== out_seq || want.last !== out_last) begin
            $display("%0t: mismatch expected code=%0d file=%0d seq=%0d last=%0b",
                     $time, want.code, want.file, want.seq, want.last);
            $display("%0t:          actual   code=%0d file=%0d seq=%0d last=%0b",
                     $time, event_code, out_file, out_seq, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives file transfers into the tracker and reports the verdict
module tb;
  import cfrt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_OTHER;
  logic [7:0]  file_id = '0;
  logic [15:0] seq_num = '0;
  logic [15:0] chunk_total = '0;
  logic [31:0] check_value = '0;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        byte_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  event_code;
  logic [7:0]  out_file;
  logic [15:0] out_seq;
  logic        out_last;
  int          fail_count, pending, event_total;
  int          cycle_count = 0;
  int          request_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;

  localparam int CycleLimit = 400000;

  chunked_file_receive_tracker_unit dut (.*);

  cfrt_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls: switch between modes every so often
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycle_count % 7) < 5;
    endcase
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one request, then wait until it is taken; bursts with random gaps
  task automatic send_request(logic [1:0] rt, logic [7:0] f, logic [15:0] sq,
                              logic [15:0] tot, logic [31:0] chkv, logic [7:0] b,
                              logic bv, logic bl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= rt;
    file_id <= f;
    seq_num <= sq;
    chunk_total <= tot;
    check_value <= chkv;
    data_byte <= b;
    byte_valid <= bv;
    byte_last <= bl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    request_count++;
  endtask

  // Send one data packet of n bytes whose sum matches its check value unless corrupt
  task automatic send_chunk(logic [7:0] f, logic [15:0] sq, int n, logic corrupt);
    logic [31:0] sum;
    logic [7:0] b;
    sum = '0;
    if (n == 0) begin
      send_request(REQ_DATA, f, sq, $urandom, corrupt ? 32'd1 : 32'd0,
                   $urandom, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      b = $urandom;
      sum += b;
      if (i < n - 1)
        send_request(REQ_DATA, f, $urandom, $urandom, $urandom, b, 1'b1, 1'b0);
      else
        send_request(REQ_DATA, f, sq, $urandom, corrupt ? sum ^ 32'h1 : sum, b, 1'b1, 1'b1);
    end
  endtask

  // One file transfer with random loss, corruption, duplicates and bad sums
  task automatic send_file(logic [7:0] f, int tot);
    // pre-pick nothing: use a fixed goal sum of 32'h0
    send_request(REQ_DEF, f, $urandom, 16'(tot), 32'h0, $urandom, $urandom, $urandom);
    for (int c = 0; c < tot; c++) begin
      if ($urandom_range(0, 9) == 0) continue;
      send_chunk(f, 16'(c), $urandom_range(0, 2), $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) send_chunk(f, 16'(c), 1, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) send_chunk(f, 16'(tot + $urandom_range(0, 3)), 1, 1'b0);
    send_request(REQ_END, f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: undefined slot, bad file ids, bad definitions, other packets
    send_request(REQ_DATA, 8'd3, 16'd0, 16'd0, 32'd0, 8'hFF, 1'b1, 1'b1);
    send_request(REQ_END, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DEF, 8'd255, 16'd0, 16'd1, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'd8, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b1);
    send_request(REQ_DEF, 8'd1, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DEF, 8'd1, 16'd0, 16'd33, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DEF, 8'd1, 16'd0, 16'hFFFF, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_OTHER, 8'hA5, 16'h5A5A, 16'hA5A5, 32'h5A5A_A5A5, 8'h5A, 1'b1, 1'b1);
    // Slot 0 with the full 32 chunks: end walks the whole map
    send_request(REQ_DEF, 8'd0, 16'd0, 16'd32, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DEF, 8'd0, 16'd0, 16'd5, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_END, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
    send_chunk(8'd0, 16'd31, 0, 1'b0);
    send_chunk(8'd0, 16'd31, 0, 1'b0);
    send_chunk(8'd0, 16'd32, 0, 1'b0);
    send_chunk(8'd0, 16'd2, 2, 1'b1);
    // Interrupted packet: partial sum cleared by an ignored request
    send_request(REQ_DATA, 8'd0, 16'd0, 16'd0, 32'd0, 8'h77, 1'b1, 1'b0);
    send_request(REQ_OTHER, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
    send_chunk(8'd0, 16'd5, 1, 1'b0);
    // Slot 7 with one chunk: last chunk with a wrong file sum, then a good file
    send_request(REQ_DEF, 8'd7, 16'd0, 16'd1, 32'hDEAD_BEEF, 8'd0, 1'b0, 1'b0);
    send_chunk(8'd7, 16'd0, 1, 1'b0);
    send_request(REQ_END, 8'd7, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
    send_request(REQ_DEF, 8'd6, 16'd0, 16'd1, 32'd0, 8'd0, 1'b0, 1'b0);
    send_chunk(8'd6, 16'd0, 0, 1'b0);
    send_chunk(8'd6, 16'd0, 0, 1'b0);
    send_request(REQ_END, 8'd6, 16'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);

    // Random: mostly file transfers into slots, some noise
    while (request_count < 220) begin
      case ($urandom_range(0, 9))
        0: send_request($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
        1: send_request(REQ_END, $urandom_range(0, 9), $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
        default: send_file($urandom_range(0, 9), $urandom_range(0, 9) == 0 ?
                           $urandom_range(1, 32) : $urandom_range(1, 4));
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("sent %0d requests, checked %0d events across file slots", request_count,
             event_total);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
